### src/gfi_pkg.sv
// ============================================================================
// gfi_pkg - shared types and constants for the gyro filter/integrator
// Holds the register indexes, the lane sequencer and product-step encodings,
// and the status struct that each lane reports to the merge stage.
// ============================================================================
package gfi_pkg;

    // Datapath width of the multiplier operands and of one sample
    localparam int MUL_W    = 64;
    localparam int SAMPLE_W = 32;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_NATURAL_FREQUENCY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DAMPING_RATIO     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LENGTH       = 2'd2;

    localparam int WN_W   = 32;
    localparam int ZETA_W = 18;
    localparam int STEP_W = 32;

    // Reset values of the configuration registers
    localparam logic [WN_W-1:0]   WN_RESET   = 32'd12451840;  // 190.0
    localparam logic [ZETA_W-1:0] ZETA_RESET = 18'd46334;     // 0.707
    localparam logic [STEP_W-1:0] STEP_RESET = 32'd4294967;   // ~0.001

    // Product steps of one lane, in issue order
    typedef enum logic [2:0] {
        OP_K,     // wn*wn          -> K
        OP_D,     // 2*zeta*wn      -> D
        OP_KERR,  // K*(u - p)
        OP_DV,    // D*v
        OP_PINC,  // v*h            -> position increment
        OP_VINC,  // drive*h        -> velocity increment
        OP_OINC,  // i*h            -> outer integral increment
        OP_IINC   // p*h            -> inner integral increment
    } gfi_op_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_ISSUE,
        LS_WAIT,
        LS_DONE
    } gfi_lane_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } gfi_lane_stat_t;

endpackage

### src/gfi_mul.sv
// ============================================================================
// gfi_mul - multi-cycle signed fractional multiplier
// Sign-magnitude 64x64 product built from four 32x32 partial products,
// shifted right by 16 or 32, truncated toward zero and saturated.
// ============================================================================
module gfi_mul
    import gfi_pkg::*;
#(
    parameter int STATE_BITS = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [MUL_W-1:0]      a,
    input  logic signed [MUL_W-1:0]      b,
    input  logic                         sh32,
    output logic                         done,
    output logic signed [STATE_BITS-1:0] result
);

    localparam int HALF_W = MUL_W / 2;
    localparam int ACC_W  = 2 * MUL_W;
    localparam logic [ACC_W-1:0] POS_LIMIT = (ACC_W'(1) << (STATE_BITS - 1)) - ACC_W'(1);
    localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(1) << (STATE_BITS - 1);

    logic [MUL_W-1:0]            xmag_reg;
    logic [MUL_W-1:0]            ymag_reg;
    logic                        neg_reg;
    logic                        sh32_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [ACC_W-1:0]            acc_next;
    logic [1:0]                  cnt_reg;
    logic                        run_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic signed [STATE_BITS-1:0] result_reg;

    logic [HALF_W-1:0]   x_limb;
    logic [HALF_W-1:0]   y_limb;
    logic [MUL_W-1:0]    pp;
    logic [ACC_W-1:0]    pp_aligned;
    logic [ACC_W-1:0]    shifted;
    logic [ACC_W-1:0]    limit;
    logic [ACC_W-1:0]    mag_sat;
    logic [STATE_BITS-1:0] res_next;

    function automatic logic [MUL_W-1:0] mag_of(input logic signed [MUL_W-1:0] v);
        mag_of = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    endfunction

    // step 0: xl*yl, 1: xl*yh, 2: xh*yl, 3: xh*yh
    assign x_limb = cnt_reg[1] ? xmag_reg[MUL_W-1:HALF_W] : xmag_reg[HALF_W-1:0];
    assign y_limb = cnt_reg[0] ? ymag_reg[MUL_W-1:HALF_W] : ymag_reg[HALF_W-1:0];
    assign pp     = MUL_W'(x_limb) * MUL_W'(y_limb);

    always_comb
    begin
        pp_aligned = ACC_W'(pp);
        if (cnt_reg[0] & cnt_reg[1])
        begin
            pp_aligned = ACC_W'(pp) << MUL_W;
        end
        else if (cnt_reg[0] | cnt_reg[1])
        begin
            pp_aligned = ACC_W'(pp) << HALF_W;
        end
        acc_next = acc_reg + pp_aligned;
    end

    assign shifted  = sh32_reg ? (acc_reg >> 32) : (acc_reg >> 16);
    assign limit    = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign mag_sat  = (shifted > limit) ? limit : shifted;
    assign res_next = neg_reg ? STATE_BITS'(-mag_sat[STATE_BITS-1:0])
                              : mag_sat[STATE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            fin_reg  <= run_reg && (cnt_reg == 2'd3);
            done_reg <= fin_reg;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xmag_reg <= mag_of(a);
            ymag_reg <= mag_of(b);
            neg_reg  <= a[MUL_W-1] ^ b[MUL_W-1];
            sh32_reg <= sh32;
            acc_reg  <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/gfi_lane.sv
// ============================================================================
// gfi_lane - one axis of the filter/integrator
// Holds the four state words of its axis and steps through eight chained
// products on its own multiplier, then commits the Euler update at once.
// ============================================================================
module gfi_lane
    import gfi_pkg::*;
#(
    parameter int STATE_BITS = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [SAMPLE_W-1:0]   sample,
    input  logic        [WN_W-1:0]       natural_frequency,
    input  logic        [ZETA_W-1:0]     damping_ratio,
    input  logic        [STEP_W-1:0]     step_length,
    input  logic                         take,
    output gfi_lane_stat_t               stat,
    output logic signed [STATE_BITS-1:0] outer
);

    localparam logic signed [STATE_BITS-1:0] SMAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] SMIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    gfi_lane_state_t state_reg;
    gfi_lane_state_t state_next;
    gfi_op_t         op_reg;

    logic signed [STATE_BITS-1:0] pos_reg;
    logic signed [STATE_BITS-1:0] vel_reg;
    logic signed [STATE_BITS-1:0] outer_reg;
    logic signed [STATE_BITS-1:0] inner_reg;

    logic signed [SAMPLE_W-1:0]   u_reg;
    logic signed [STATE_BITS-1:0] k_reg;
    logic signed [STATE_BITS-1:0] d_reg;
    logic signed [STATE_BITS-1:0] kerr_reg;
    logic signed [STATE_BITS-1:0] dv_reg;
    logic signed [STATE_BITS-1:0] pinc_reg;
    logic signed [STATE_BITS-1:0] vinc_reg;
    logic signed [STATE_BITS-1:0] oinc_reg;

    logic                         mul_start;
    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic                         mul_sh32;
    logic                         mul_done;
    logic signed [STATE_BITS-1:0] mul_result;

    function automatic logic signed [STATE_BITS-1:0] add_sat(
        input logic signed [STATE_BITS-1:0] x,
        input logic signed [STATE_BITS-1:0] y
    );
        logic signed [STATE_BITS:0] s;
        s = (STATE_BITS+1)'(x) + (STATE_BITS+1)'(y);
        if (s[STATE_BITS] != s[STATE_BITS-1])
        begin
            add_sat = s[STATE_BITS] ? SMIN : SMAX;
        end
        else
        begin
            add_sat = s[STATE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sub_sat(
        input logic signed [STATE_BITS-1:0] x,
        input logic signed [STATE_BITS-1:0] y
    );
        logic signed [STATE_BITS:0] s;
        s = (STATE_BITS+1)'(x) - (STATE_BITS+1)'(y);
        if (s[STATE_BITS] != s[STATE_BITS-1])
        begin
            sub_sat = s[STATE_BITS] ? SMIN : SMAX;
        end
        else
        begin
            sub_sat = s[STATE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [MUL_W-1:0] ext(input logic signed [STATE_BITS-1:0] x);
        ext = MUL_W'(x);
    endfunction

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LS_IDLE:
            begin
                if (start)
                begin
                    state_next = LS_ISSUE;
                end
            end
            LS_ISSUE:
            begin
                state_next = LS_WAIT;
            end
            LS_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (op_reg == OP_IINC) ? LS_DONE : LS_ISSUE;
                end
            end
            LS_DONE:
            begin
                if (take)
                begin
                    state_next = LS_IDLE;
                end
            end
            default:
            begin
                state_next = LS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.idle = (state_reg == LS_IDLE);
        stat.done = (state_reg == LS_DONE);
        mul_start = (state_reg == LS_ISSUE);
    end

    // Operand selection for the product in flight
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_sh32 = 1'b0;
        unique case (op_reg)
            OP_K:
            begin
                mul_a = MUL_W'(natural_frequency);
                mul_b = MUL_W'(natural_frequency);
            end
            OP_D:
            begin
                mul_a = MUL_W'({damping_ratio, 1'b0});
                mul_b = MUL_W'(natural_frequency);
            end
            OP_KERR:
            begin
                mul_a = ext(k_reg);
                mul_b = ext(sub_sat(STATE_BITS'(u_reg), pos_reg));
            end
            OP_DV:
            begin
                mul_a = ext(d_reg);
                mul_b = ext(vel_reg);
            end
            OP_PINC:
            begin
                mul_a    = ext(vel_reg);
                mul_b    = MUL_W'(step_length);
                mul_sh32 = 1'b1;
            end
            OP_VINC:
            begin
                mul_a    = ext(sub_sat(kerr_reg, dv_reg));
                mul_b    = MUL_W'(step_length);
                mul_sh32 = 1'b1;
            end
            OP_OINC:
            begin
                mul_a    = ext(inner_reg);
                mul_b    = MUL_W'(step_length);
                mul_sh32 = 1'b1;
            end
            OP_IINC:
            begin
                mul_a    = ext(pos_reg);
                mul_b    = MUL_W'(step_length);
                mul_sh32 = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    gfi_mul #(
        .STATE_BITS (STATE_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .sh32   (mul_sh32),
        .done   (mul_done),
        .result (mul_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
            op_reg    <= OP_K;
            pos_reg   <= '0;
            vel_reg   <= '0;
            outer_reg <= '0;
            inner_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == LS_IDLE && start)
            begin
                op_reg <= OP_K;
            end
            else if (state_reg == LS_WAIT && mul_done)
            begin
                if (op_reg == OP_IINC)
                begin
                    // commit: every increment came from the old state
                    pos_reg   <= add_sat(pos_reg, pinc_reg);
                    vel_reg   <= add_sat(vel_reg, vinc_reg);
                    outer_reg <= add_sat(outer_reg, oinc_reg);
                    inner_reg <= add_sat(inner_reg, mul_result);
                end
                else
                begin
                    op_reg <= gfi_op_t'(op_reg + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == LS_IDLE && start)
        begin
            u_reg <= sample;
        end
        if (state_reg == LS_WAIT && mul_done)
        begin
            unique case (op_reg)
                OP_K:    k_reg    <= mul_result;
                OP_D:    d_reg    <= mul_result;
                OP_KERR: kerr_reg <= mul_result;
                OP_DV:   dv_reg   <= mul_result;
                OP_PINC: pinc_reg <= mul_result;
                OP_VINC: vinc_reg <= mul_result;
                OP_OINC: oinc_reg <= mul_result;
                OP_IINC: ;
                default: ;
            endcase
        end
    end

    assign outer = outer_reg;

endmodule

### src/three_axis_gyro_filter_integrator_unit.sv
// ============================================================================
// three_axis_gyro_filter_integrator_unit - gyro low-pass and double integrator
// Per axis: second-order forward-Euler low-pass on the rate sample, followed
// by two integrators; the result item carries the three saturated angles.
// ============================================================================
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  s_axis_tdata: one rate per axis
//  m_axis    out  m_axis_tvalid / m_axis_tready  m_axis_tdata: one angle per axis
//  cfg       in   cfg_we (no wait)               cfg_addr, cfg_wdata
//
//  - Each item runs eight chained products per lane, each one issued to the
//    lane's own multiplier and built there from four 32x32 partial products
//    before it is shifted, truncated and saturated.
//  - All lanes run in lockstep; a new item is taken once every lane is idle.
//  - The output register parts the sides: the next item may be accepted while
//    a result still waits on m_axis_tready.
//  - rst_n (async, active low) clears all filter state and restores the
//    register defaults; there is no clearing sweep.
//
module three_axis_gyro_filter_integrator_unit
    import gfi_pkg::*;
#(
    parameter int AXES       = 3,
    parameter int STATE_BITS = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input item
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [AXES*SAMPLE_W-1:0]   s_axis_tdata,  // rate_x, rate_y, rate_z (low to high)
    // result item
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [AXES*SAMPLE_W-1:0]   m_axis_tdata,  // angle_alpha, angle_beta, angle_gamma
    // configuration writes
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [WN_W-1:0]            cfg_wdata
);

    localparam logic signed [STATE_BITS-1:0] OUT_MAX = STATE_BITS'(32'sh7FFF_FFFF);
    localparam logic signed [STATE_BITS-1:0] OUT_MIN = STATE_BITS'(-64'sh8000_0000);

    logic [WN_W-1:0]   wn_reg;
    logic [ZETA_W-1:0] zeta_reg;
    logic [STEP_W-1:0] step_reg;

    gfi_lane_stat_t               lane_stat [AXES];
    logic signed [STATE_BITS-1:0] lane_outer [AXES];
    logic [AXES-1:0]              lane_idle;
    logic [AXES-1:0]              lane_done;

    logic                         in_fire;
    logic                         res_ready;
    logic                         take;
    logic                         out_valid_reg;
    logic [AXES*SAMPLE_W-1:0]     out_data_reg;
    logic [AXES*SAMPLE_W-1:0]     merged;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wn_reg   <= WN_RESET;
            zeta_reg <= ZETA_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NATURAL_FREQUENCY: wn_reg   <= cfg_wdata;
                REG_DAMPING_RATIO:     zeta_reg <= cfg_wdata[ZETA_W-1:0];
                REG_STEP_LENGTH:       step_reg <= cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- lanes ----------------
    assign s_axis_tready = &lane_idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        gfi_lane #(
            .STATE_BITS (STATE_BITS)
        ) u_lane (
            .clk               (clk),
            .rst_n             (rst_n),
            .start             (in_fire),
            .sample            (s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .natural_frequency (wn_reg),
            .damping_ratio     (zeta_reg),
            .step_length       (step_reg),
            .take              (take),
            .stat              (lane_stat[g]),
            .outer             (lane_outer[g])
        );

        assign lane_idle[g] = lane_stat[g].idle;
        assign lane_done[g] = lane_stat[g].done;

        // merge: clamp each outer integral to a 32-bit angle
        always_comb
        begin
            if (lane_outer[g] > OUT_MAX)
            begin
                merged[g*SAMPLE_W +: SAMPLE_W] = OUT_MAX[SAMPLE_W-1:0];
            end
            else if (lane_outer[g] < OUT_MIN)
            begin
                merged[g*SAMPLE_W +: SAMPLE_W] = OUT_MIN[SAMPLE_W-1:0];
            end
            else
            begin
                merged[g*SAMPLE_W +: SAMPLE_W] = lane_outer[g][SAMPLE_W-1:0];
            end
        end
    end

    // ---------------- output register ----------------
    assign res_ready = &lane_done;
    assign take      = res_ready && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= merged;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ((&lane_done) == (|lane_done)) && ((&lane_idle) == (|lane_idle)))
        else $error("lanes out of step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_axis_tvalid)
        else $error("merged result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!out_valid_reg || m_axis_tready))
        else $error("pending result overwritten");

endmodule
